// ----- rtl/websocket_frame_deframer_top_defines.svh -----
// assertion macros shared by the websocket deframer modules
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/wsd_pkg.sv -----
// types, constants and helpers for the websocket deframer
package wsd_pkg;

	localparam int LEN_W      = 17;
	localparam int PING_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int MAX_PUSH   = 4;
	localparam int PUSH_W     = 3;
	localparam int QUEUE_AW   = 3;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam int TDATA_W    = 32;

	typedef enum logic [1:0] {
		KIND_TEXT  = 2'd0,
		KIND_END   = 2'd1,
		KIND_PONG  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_CLOSE     = 3'd0,
		ERR_UNMASKED  = 3'd1,
		ERR_OVERSIZE  = 3'd2,
		ERR_FRAGMENT  = 3'd3,
		ERR_TEXT_LONG = 3'd4,
		ERR_PING_LONG = 3'd5
	} err_t;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXT16   = 6'b000100,
		PH_EXT64   = 6'b001000,
		PH_MASK    = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_TEXT    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_PING    = 2'd2;

	localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD = 17'd65536;
	localparam logic [LEN_W-1:0]  RST_MAX_TEXT    = 17'd4094;
	localparam logic [PING_W-1:0] RST_MAX_PING    = 16'd8192;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
	localparam logic [7:0] PONG_HEADER    = 8'h8A;
	localparam logic [7:0] PONG_EXT16     = 8'd126;
	localparam logic [LEN_W-1:0] PONG_SHORT_MAX = 17'd125;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] MASK_BYTES  = 4'd4;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [LEN_W-1:0]  msg_length;
		err_t              error_code;
	} result_t;

	typedef struct packed {
		logic [PUSH_W-1:0]           num;
		result_t [MAX_PUSH-1:0]      res;
	} push_t;

	typedef struct packed {
		logic [LEN_W-1:0]  max_payload_len;
		logic [LEN_W-1:0]  max_text_len;
		logic [PING_W-1:0] max_ping_len;
	} cfg_t;

	function automatic result_t mk_result(kind_t k, logic [BYTE_W-1:0] d, logic l,
			logic [LEN_W-1:0] len, err_t e);
		result_t r;
		r.kind       = k;
		r.data       = d;
		r.last       = l;
		r.msg_length = len;
		r.error_code = e;
		return r;
	endfunction

endpackage

// ----- rtl/wsd_parser.sv -----
// frame header parser, unmasking and result generation for one byte per cycle while fire is high
`include "websocket_frame_deframer_top_defines.svh"

module wsd_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [wsd_pkg::BYTE_W-1:0]    rx_byte,
	input  wsd_pkg::cfg_t                 cfg,
	output wsd_pkg::push_t                push
);

	wsd_pkg::phase_t               phase_q, phase_n;
	logic                          failed_q, failed_n;
	logic                          fin_q, fin_n;
	logic [3:0]                    op_q, op_n;
	logic                          mask_q, mask_n;
	logic [wsd_pkg::LEN_W-1:0]     len_q, len_n;
	logic                          ovf_q, ovf_n;
	logic [3:0]                    cnt_q, cnt_n;
	logic [31:0]                   key_q, key_n;
	logic [wsd_pkg::LEN_W-1:0]     idx_q, idx_n;
	wsd_pkg::push_t                push_n;

	always_comb begin
		logic                      len_done;
		logic                      hdr_done;
		logic                      fail_now;
		wsd_pkg::err_t             fail_code;
		logic [7:0]                key_byte;
		logic [7:0]                d;
		logic                      done;

		phase_n   = phase_q;
		failed_n  = failed_q;
		fin_n     = fin_q;
		op_n      = op_q;
		mask_n    = mask_q;
		len_n     = len_q;
		ovf_n     = ovf_q;
		cnt_n     = cnt_q;
		key_n     = key_q;
		idx_n     = idx_q;
		push_n    = '0;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		fail_now  = 1'b0;
		fail_code = wsd_pkg::ERR_CLOSE;
		key_byte  = '0;
		d         = '0;
		done      = 1'b0;

		if (fire && !failed_q) begin
			case (phase_q)
				wsd_pkg::PH_HDR0: begin
					fin_n   = rx_byte[7];
					op_n    = rx_byte[3:0];
					phase_n = wsd_pkg::PH_HDR1;
				end
				wsd_pkg::PH_HDR1: begin
					mask_n = rx_byte[7];
					len_n  = '0;
					ovf_n  = 1'b0;
					cnt_n  = '0;
					if (rx_byte[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
						phase_n = wsd_pkg::PH_EXT16;
					end else if (rx_byte[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
						phase_n = wsd_pkg::PH_EXT64;
					end else begin
						len_n    = {10'd0, rx_byte[6:0]};
						len_done = 1'b1;
					end
				end
				wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
					if (len_q[16:9] != '0) begin
						ovf_n = 1'b1;
					end
					len_n = {len_q[8:0], rx_byte};
					cnt_n = cnt_q + 4'd1;
					if (cnt_n >= ((phase_q == wsd_pkg::PH_EXT16) ?
							wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES)) begin
						len_done = 1'b1;
					end
				end
				wsd_pkg::PH_MASK: begin
					key_n = {key_q[23:0], rx_byte};
					cnt_n = cnt_q + 4'd1;
					if (cnt_n >= wsd_pkg::MASK_BYTES) begin
						hdr_done = 1'b1;
					end
				end
				wsd_pkg::PH_PAYLOAD: begin
					case (idx_q[1:0])
						2'd0: key_byte = key_q[31:24];
						2'd1: key_byte = key_q[23:16];
						2'd2: key_byte = key_q[15:8];
						default: key_byte = key_q[7:0];
					endcase
					d     = rx_byte ^ key_byte;
					idx_n = idx_q + wsd_pkg::LEN_W'(1);
					done  = (idx_n >= len_q);
					if (op_q == wsd_pkg::OP_PING) begin
						push_n.num    = 3'd1;
						push_n.res[0] = wsd_pkg::mk_result(wsd_pkg::KIND_PONG, d, done,
							'0, wsd_pkg::ERR_CLOSE);
					end else if (op_q == wsd_pkg::OP_TEXT) begin
						push_n.num    = done ? 3'd2 : 3'd1;
						push_n.res[0] = wsd_pkg::mk_result(wsd_pkg::KIND_TEXT, d, 1'b0,
							'0, wsd_pkg::ERR_CLOSE);
						push_n.res[1] = wsd_pkg::mk_result(wsd_pkg::KIND_END, '0, 1'b0,
							len_q, wsd_pkg::ERR_CLOSE);
					end
					if (done) begin
						phase_n = wsd_pkg::PH_HDR0;
					end
				end
				default: begin
					phase_n = wsd_pkg::PH_HDR0;
				end
			endcase

			if (len_done) begin
				cnt_n = '0;
				if (!mask_n) begin
					fail_now  = 1'b1;
					fail_code = wsd_pkg::ERR_UNMASKED;
				end else if (ovf_n || (len_n > cfg.max_payload_len)) begin
					fail_now  = 1'b1;
					fail_code = wsd_pkg::ERR_OVERSIZE;
				end else begin
					key_n   = '0;
					phase_n = wsd_pkg::PH_MASK;
				end
			end

			if (hdr_done) begin
				idx_n   = '0;
				cnt_n   = '0;
				phase_n = (len_q == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
				if (op_q == wsd_pkg::OP_CLOSE) begin
					fail_now  = 1'b1;
					fail_code = wsd_pkg::ERR_CLOSE;
				end else if (op_q == wsd_pkg::OP_PING) begin
					if (len_q > {1'b0, cfg.max_ping_len}) begin
						fail_now  = 1'b1;
						fail_code = wsd_pkg::ERR_PING_LONG;
					end else begin
						push_n.res[0] = wsd_pkg::mk_result(wsd_pkg::KIND_PONG,
							wsd_pkg::PONG_HEADER, 1'b0, '0, wsd_pkg::ERR_CLOSE);
						if (len_q <= wsd_pkg::PONG_SHORT_MAX) begin
							push_n.num    = 3'd2;
							push_n.res[1] = wsd_pkg::mk_result(wsd_pkg::KIND_PONG,
								len_q[7:0], (len_q == '0), '0, wsd_pkg::ERR_CLOSE);
						end else begin
							push_n.num    = 3'd4;
							push_n.res[1] = wsd_pkg::mk_result(wsd_pkg::KIND_PONG,
								wsd_pkg::PONG_EXT16, 1'b0, '0, wsd_pkg::ERR_CLOSE);
							push_n.res[2] = wsd_pkg::mk_result(wsd_pkg::KIND_PONG,
								len_q[15:8], 1'b0, '0, wsd_pkg::ERR_CLOSE);
							push_n.res[3] = wsd_pkg::mk_result(wsd_pkg::KIND_PONG,
								len_q[7:0], 1'b0, '0, wsd_pkg::ERR_CLOSE);
						end
					end
				end else if (op_q == wsd_pkg::OP_TEXT) begin
					if (!fin_q) begin
						fail_now  = 1'b1;
						fail_code = wsd_pkg::ERR_FRAGMENT;
					end else if (len_q > cfg.max_text_len) begin
						fail_now  = 1'b1;
						fail_code = wsd_pkg::ERR_TEXT_LONG;
					end else if (len_q == '0) begin
						push_n.num    = 3'd1;
						push_n.res[0] = wsd_pkg::mk_result(wsd_pkg::KIND_END, '0, 1'b0,
							'0, wsd_pkg::ERR_CLOSE);
					end
				end
			end

			if (fail_now) begin
				failed_n      = 1'b1;
				phase_n       = wsd_pkg::PH_HDR0;
				push_n        = '0;
				push_n.num    = 3'd1;
				push_n.res[0] = wsd_pkg::mk_result(wsd_pkg::KIND_ERROR, '0, 1'b0, '0,
					fail_code);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsd_pkg::PH_HDR0;
			failed_q <= 1'b0;
			fin_q    <= 1'b0;
			op_q     <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			cnt_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
		end else begin
			phase_q  <= phase_n;
			failed_q <= failed_n;
			fin_q    <= fin_n;
			op_q     <= op_n;
			mask_q   <= mask_n;
			len_q    <= len_n;
			ovf_q    <= ovf_n;
			cnt_q    <= cnt_n;
			key_q    <= key_n;
			idx_q    <= idx_n;
		end
	end

	assign push = push_n;

	`WSD_ASSERT_NEXT(a_failed_sticky, failed_q, failed_q, "error state left without reset")
	`WSD_ASSERT_NOW(a_failed_silent, failed_q, push_n.num == '0, "results after error")
	`WSD_ASSERT_NOW(a_payload_len, phase_q == wsd_pkg::PH_PAYLOAD, len_q != '0,
		"payload phase with zero length")

endmodule

// ----- rtl/wsd_queue.sv -----
// result queue taking up to four entries per cycle and giving one per cycle while out_ready is high
`include "websocket_frame_deframer_top_defines.svh"

module wsd_queue #(
	parameter int QUEUE_AW = wsd_pkg::QUEUE_AW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wsd_pkg::push_t   push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output wsd_pkg::result_t out_res
);

	localparam int DEPTH = 1 << QUEUE_AW;
	localparam int CNT_W = QUEUE_AW + 1;

	wsd_pkg::result_t    mem_q [DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];
	assign room      = (cnt_q <= CNT_W'(DEPTH - wsd_pkg::MAX_PUSH));

	always_ff @(posedge clk) begin
		for (int i = 0; i < wsd_pkg::MAX_PUSH; i++) begin
			if (wsd_pkg::PUSH_W'(i) < push.num) begin
				mem_q[wr_q + QUEUE_AW'(i)] <= push.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QUEUE_AW'(push.num);
			rd_q  <= rd_q + QUEUE_AW'(pop);
			cnt_q <= cnt_q + CNT_W'(push.num) - CNT_W'(pop);
		end
	end

	`WSD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
	`WSD_ASSERT_NOW(a_push_room, push.num != '0,
		cnt_q <= CNT_W'(DEPTH - wsd_pkg::MAX_PUSH), "push without room")
	`WSD_ASSERT_NEXT(a_pop_count, pop && (push.num == '0),
		cnt_q == $past(cnt_q) - CNT_W'(1), "pop did not lower count")

endmodule

// ----- rtl/websocket_frame_deframer_top.sv -----
// websocket client frame deframer: byte stream in, text/pong/error stream out
// a byte's results pass the input register and the result queue before they can be taken
// throughput: one byte per cycle while the queue has room; the parser is a single registered pass
// every byte holds the input until four queue slots are free, room for a ping header burst of four results
// reset: arst_n clears the parser, empties the result queue and restores register defaults
module websocket_frame_deframer_top #(
	parameter int QUEUE_AW = wsd_pkg::QUEUE_AW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wsd_pkg::BYTE_W-1:0]        s_tdata,   // rx_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wsd_pkg::TDATA_W-1:0]       m_tdata,   // data, msg_length, error_code
	output logic                              m_tlast,
	output logic [1:0]                        m_tuser,   // kind
	input  logic                              cfg_we,
	input  logic [wsd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [wsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	wsd_pkg::cfg_t                  cfg_q;
	logic [wsd_pkg::BYTE_W-1:0]     byte_s1;
	logic                           valid_s1;
	logic                           room;
	logic                           consume;
	wsd_pkg::push_t                 push;
	wsd_pkg::result_t               out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_len <= wsd_pkg::RST_MAX_PAYLOAD;
			cfg_q.max_text_len    <= wsd_pkg::RST_MAX_TEXT;
			cfg_q.max_ping_len    <= wsd_pkg::RST_MAX_PING;
		end else if (cfg_we) begin
			case (cfg_addr)
				wsd_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload_len <= cfg_wdata;
				wsd_pkg::REG_MAX_TEXT:    cfg_q.max_text_len    <= cfg_wdata;
				wsd_pkg::REG_MAX_PING:    cfg_q.max_ping_len    <= cfg_wdata[wsd_pkg::PING_W-1:0];
				default: ;
			endcase
		end
	end

	assign consume  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (consume),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.push    (push)
	);

	wsd_queue #(
		.QUEUE_AW (QUEUE_AW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {4'd0, out_res.error_code, out_res.msg_length, out_res.data};
	assign m_tlast = out_res.last;
	assign m_tuser = out_res.kind;

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the websocket frame deframer: byte frames in, predicted results out
module testbench;

	localparam int WATCHDOG_CYCLES = 500;
	localparam logic [wsd_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_PONG = 4'hA;

	typedef enum {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;

	class deframe_scoreboard;
		wsd_pkg::phase_t                parse_at;
		logic                           halted;
		logic                           fin_bit;
		logic [3:0]                     opcode;
		logic                           masked;
		logic [wsd_pkg::LEN_W-1:0]      plen;
		logic                           len_ovf;
		logic [3:0]                     field_cnt;
		logic [31:0]                    key_word;
		logic [wsd_pkg::LEN_W-1:0]      idx;
		logic [wsd_pkg::LEN_W-1:0]      lim_payload;
		logic [wsd_pkg::LEN_W-1:0]      lim_text;
		logic [wsd_pkg::PING_W-1:0]     lim_ping;
		wsd_pkg::result_t               pending_items[$];
		int                             mismatches;

		function new();
			parse_at    = wsd_pkg::PH_HDR0;
			halted      = 1'b0;
			fin_bit     = 1'b0;
			opcode      = '0;
			masked      = 1'b0;
			plen        = '0;
			len_ovf     = 1'b0;
			field_cnt   = '0;
			key_word    = '0;
			idx         = '0;
			lim_payload = wsd_pkg::RST_MAX_PAYLOAD;
			lim_text    = wsd_pkg::RST_MAX_TEXT;
			lim_ping    = wsd_pkg::RST_MAX_PING;
			mismatches  = 0;
		endfunction

		function int pending();
			return pending_items.size();
		endfunction

		function void set_reg(logic [wsd_pkg::CFG_ADDR_W-1:0] addr,
				logic [wsd_pkg::CFG_DATA_W-1:0] value);
			case (addr)
				wsd_pkg::REG_MAX_PAYLOAD: lim_payload = value;
				wsd_pkg::REG_MAX_TEXT:    lim_text = value;
				wsd_pkg::REG_MAX_PING:    lim_ping = value[wsd_pkg::PING_W-1:0];
				default: ;
			endcase
		endfunction

		function void queue_result(wsd_pkg::kind_t k, logic [wsd_pkg::BYTE_W-1:0] d, logic l,
				logic [wsd_pkg::LEN_W-1:0] n, wsd_pkg::err_t e);
			wsd_pkg::result_t r;
			r.kind       = k;
			r.data       = d;
			r.last       = l;
			r.msg_length = n;
			r.error_code = e;
			pending_items.push_back(r);
		endfunction

		function void raise_error(wsd_pkg::err_t e);
			halted   = 1'b1;
			parse_at = wsd_pkg::PH_HDR0;
			queue_result(wsd_pkg::KIND_ERROR, '0, 1'b0, '0, e);
		endfunction

		function void close_length();
			field_cnt = '0;
			if (!masked) begin
				raise_error(wsd_pkg::ERR_UNMASKED);
			end else if (len_ovf || plen > lim_payload) begin
				raise_error(wsd_pkg::ERR_OVERSIZE);
			end else begin
				key_word = '0;
				parse_at = wsd_pkg::PH_MASK;
			end
		endfunction

		function void close_header();
			idx       = '0;
			field_cnt = '0;
			parse_at  = (plen == 0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
			if (opcode == wsd_pkg::OP_CLOSE) begin
				raise_error(wsd_pkg::ERR_CLOSE);
			end else if (opcode == wsd_pkg::OP_PING) begin
				if (plen > lim_ping) begin
					raise_error(wsd_pkg::ERR_PING_LONG);
				end else begin
					queue_result(wsd_pkg::KIND_PONG, wsd_pkg::PONG_HEADER, 1'b0, '0,
						wsd_pkg::ERR_CLOSE);
					if (plen <= wsd_pkg::PONG_SHORT_MAX) begin
						queue_result(wsd_pkg::KIND_PONG, plen[7:0], plen == 0, '0,
							wsd_pkg::ERR_CLOSE);
					end else begin
						queue_result(wsd_pkg::KIND_PONG, wsd_pkg::PONG_EXT16, 1'b0, '0,
							wsd_pkg::ERR_CLOSE);
						queue_result(wsd_pkg::KIND_PONG, plen[15:8], 1'b0, '0,
							wsd_pkg::ERR_CLOSE);
						queue_result(wsd_pkg::KIND_PONG, plen[7:0], 1'b0, '0,
							wsd_pkg::ERR_CLOSE);
					end
				end
			end else if (opcode == wsd_pkg::OP_TEXT) begin
				if (!fin_bit)
					raise_error(wsd_pkg::ERR_FRAGMENT);
				else if (plen > lim_text)
					raise_error(wsd_pkg::ERR_TEXT_LONG);
				else if (plen == 0)
					queue_result(wsd_pkg::KIND_END, '0, 1'b0, '0, wsd_pkg::ERR_CLOSE);
			end
		endfunction

		// advance the parser by one accepted rx transaction
		function void absorb_rx_byte(logic [wsd_pkg::BYTE_W-1:0] b);
			logic [6:0]                 code7;
			logic [wsd_pkg::BYTE_W-1:0] kb;
			logic [wsd_pkg::BYTE_W-1:0] d;
			if (halted)
				return;
			case (parse_at)
				wsd_pkg::PH_HDR0: begin
					fin_bit  = b[7];
					opcode   = b[3:0];
					parse_at = wsd_pkg::PH_HDR1;
				end
				wsd_pkg::PH_HDR1: begin
					masked    = b[7];
					code7     = b[6:0];
					plen      = '0;
					len_ovf   = 1'b0;
					field_cnt = '0;
					if (code7 == wsd_pkg::LEN_CODE_EXT16) begin
						parse_at = wsd_pkg::PH_EXT16;
					end else if (code7 == wsd_pkg::LEN_CODE_EXT64) begin
						parse_at = wsd_pkg::PH_EXT64;
					end else begin
						plen = wsd_pkg::LEN_W'(code7);
						close_length();
					end
				end
				wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
					if (plen[wsd_pkg::LEN_W-1:9] != 0)
						len_ovf = 1'b1;
					plen      = {plen[8:0], b};
					field_cnt = field_cnt + 4'd1;
					if (field_cnt >= ((parse_at == wsd_pkg::PH_EXT16) ?
							wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES))
						close_length();
				end
				wsd_pkg::PH_MASK: begin
					key_word  = {key_word[23:0], b};
					field_cnt = field_cnt + 4'd1;
					if (field_cnt >= wsd_pkg::MASK_BYTES)
						close_header();
				end
				wsd_pkg::PH_PAYLOAD: begin
					kb  = key_word[8 * (3 - int'(idx[1:0])) +: 8];
					d   = b ^ kb;
					idx = idx + wsd_pkg::LEN_W'(1);
					if (opcode == wsd_pkg::OP_PING) begin
						queue_result(wsd_pkg::KIND_PONG, d, idx >= plen, '0,
							wsd_pkg::ERR_CLOSE);
					end else if (opcode == wsd_pkg::OP_TEXT) begin
						queue_result(wsd_pkg::KIND_TEXT, d, 1'b0, '0, wsd_pkg::ERR_CLOSE);
						if (idx >= plen)
							queue_result(wsd_pkg::KIND_END, '0, 1'b0, plen,
								wsd_pkg::ERR_CLOSE);
					end
					if (idx >= plen)
						parse_at = wsd_pkg::PH_HDR0;
				end
				default: parse_at = wsd_pkg::PH_HDR0;
			endcase
		endfunction

		function void note_mismatch(string msg);
			if (mismatches < 10)
				$display("mismatch: %s", msg);
			mismatches++;
		endfunction

		function void check_output(logic [1:0] user, logic last,
				logic [wsd_pkg::TDATA_W-1:0] tdata);
			wsd_pkg::result_t want;
			if (pending_items.size() == 0) begin
				note_mismatch($sformatf("unexpected transaction kind %0d tdata %h last %b",
					user, tdata, last));
				return;
			end
			want = pending_items.pop_front();
			if (user !== want.kind || last !== want.last
					|| tdata[wsd_pkg::BYTE_W-1:0] !== want.data
					|| tdata[wsd_pkg::BYTE_W +: wsd_pkg::LEN_W] !== want.msg_length
					|| tdata[wsd_pkg::BYTE_W+wsd_pkg::LEN_W +: 3] !== want.error_code
					|| tdata[wsd_pkg::TDATA_W-1:wsd_pkg::BYTE_W+wsd_pkg::LEN_W+3] !== '0)
				note_mismatch({
					$sformatf("exp kind %0d data %h last %b len %0d err %0d, ",
						want.kind, want.data, want.last, want.msg_length,
						want.error_code),
					$sformatf("got kind %0d data %h last %b len %0d err %0d pad %h",
						user, tdata[wsd_pkg::BYTE_W-1:0], last,
						tdata[wsd_pkg::BYTE_W +: wsd_pkg::LEN_W],
						tdata[wsd_pkg::BYTE_W+wsd_pkg::LEN_W +: 3],
						tdata[wsd_pkg::TDATA_W-1:wsd_pkg::BYTE_W+wsd_pkg::LEN_W+3])});
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	logic [wsd_pkg::BYTE_W-1:0]         s_tdata = '0;
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [wsd_pkg::TDATA_W-1:0]        m_tdata;
	logic                               m_tlast;
	logic [1:0]                         m_tuser;
	logic                               cfg_we = 1'b0;
	logic [wsd_pkg::CFG_ADDR_W-1:0]     cfg_addr = '0;
	logic [wsd_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

	deframe_scoreboard sb;
	int  tx_count = 0;
	bit  tx_idle = 1'b1;
	bit  tx_idle_phase = 1'b1;
	bit  rx_idle = 1'b1;
	int  rx_hold = 0;
	int  stall_cycles = 0;

	websocket_frame_deframer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// result sink with random backpressure while rx_idle is set, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_output(m_tuser, m_tlast, m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (!rx_idle) begin
				m_tready <= 1'b1;
			end else if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				rx_hold = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if (stall_cycles >= WATCHDOG_CYCLES) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send_byte(logic [wsd_pkg::BYTE_W-1:0] b);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.absorb_rx_byte(b);
		tx_count++;
	endtask

	task automatic send_frame(logic fin_b, logic [3:0] op, logic mask_b, logic [63:0] len,
			len_enc_t enc, logic [31:0] key, int body);
		send_byte({fin_b, 3'($urandom), op});
		case (enc)
			ENC_SHORT: send_byte({mask_b, len[6:0]});
			ENC_EXT16: begin
				send_byte({mask_b, wsd_pkg::LEN_CODE_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({mask_b, wsd_pkg::LEN_CODE_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8 * i +: 8]);
			end
		endcase
		if (mask_b)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		repeat (body) send_byte(8'($urandom));
	endtask

	// well-formed frame that stays within the current limits
	task automatic random_frame();
		logic [3:0] op;
		logic       fin_b;
		int         len;
		int         cap;
		int         r;
		len_enc_t   enc;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			op = wsd_pkg::OP_TEXT;
		end else if (r < 7) begin
			op = wsd_pkg::OP_PING;
		end else if (r == 7) begin
			op = OP_PONG;
		end else if (r == 8) begin
			op = OP_CONT;
		end else begin
			r  = $urandom_range(0, 10);
			op = (r < 6) ? 4'(r + 2) : 4'(r + 5);
		end
		fin_b = (op == wsd_pkg::OP_TEXT) ? 1'b1 : 1'($urandom);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 131) : $urandom_range(0, 12);
		cap = int'(sb.lim_payload);
		if (op == wsd_pkg::OP_TEXT && int'(sb.lim_text) < cap)
			cap = int'(sb.lim_text);
		if (op == wsd_pkg::OP_PING && int'(sb.lim_ping) < cap)
			cap = int'(sb.lim_ping);
		if (len > cap)
			len = cap;
		r = $urandom_range(0, 9);
		if (len > 125)
			enc = (r < 5) ? ENC_EXT16 : ENC_EXT64;
		else
			enc = (r < 7) ? ENC_SHORT : (r < 9) ? ENC_EXT16 : ENC_EXT64;
		tx_idle = tx_idle_phase && ($urandom_range(0, 2) != 0);
		send_frame(fin_b, op, 1'b1, 64'(len), enc, $urandom, len);
	endtask

	// one broken frame, then trailing bytes that must be ignored
	task automatic error_frame();
		wsd_pkg::err_t pick;
		logic [63:0]   len;
		pick = wsd_pkg::err_t'($urandom_range(0, 5));
		case (pick)
			wsd_pkg::ERR_CLOSE:
				send_frame(1'b1, wsd_pkg::OP_CLOSE, 1'b1, 64'd3, ENC_SHORT, $urandom, 3);
			wsd_pkg::ERR_UNMASKED:
				send_frame(1'($urandom), 4'($urandom), 1'b0, 64'd3, ENC_SHORT, $urandom, 3);
			wsd_pkg::ERR_OVERSIZE: begin
				if ($urandom_range(0, 1))
					len = {$urandom, $urandom} | (64'd1 << $urandom_range(17, 63));
				else
					len = 64'(sb.lim_payload) + 64'd1;
				send_frame(1'b1, wsd_pkg::OP_TEXT, 1'b1, len, ENC_EXT64, $urandom, 4);
			end
			wsd_pkg::ERR_FRAGMENT:
				send_frame(1'b0, wsd_pkg::OP_TEXT, 1'b1, 64'd3, ENC_SHORT, $urandom, 3);
			wsd_pkg::ERR_TEXT_LONG:
				send_frame(1'b1, wsd_pkg::OP_TEXT, 1'b1, 64'(sb.lim_text) + 64'd1,
					ENC_EXT64, $urandom, 4);
			default:
				send_frame(1'b1, wsd_pkg::OP_PING, 1'b1, 64'(sb.lim_ping) + 64'd1,
					ENC_EXT64, $urandom, 4);
		endcase
		repeat (6) send_byte(8'($urandom));
	endtask

	task automatic rand_phase(int budget);
		int start;
		start = tx_count;
		while (tx_count - start < budget)
			random_frame();
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [wsd_pkg::CFG_ADDR_W-1:0] addr,
			logic [wsd_pkg::CFG_DATA_W-1:0] value);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(addr, value);
	endtask

	task automatic set_limits(logic [wsd_pkg::LEN_W-1:0] pay, logic [wsd_pkg::LEN_W-1:0] txt,
			logic [wsd_pkg::PING_W-1:0] png);
		write_reg(wsd_pkg::REG_MAX_PAYLOAD, pay);
		write_reg(wsd_pkg::REG_MAX_TEXT, txt);
		write_reg(wsd_pkg::REG_MAX_PING, wsd_pkg::CFG_DATA_W'(png));
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: empty text, empty ping, short text with a 16-bit length
		send_frame(1'b1, wsd_pkg::OP_TEXT, 1'b1, 64'd0, ENC_SHORT, $urandom, 0);
		send_frame(1'b1, wsd_pkg::OP_PING, 1'b1, 64'd0, ENC_SHORT, $urandom, 0);
		send_frame(1'b1, wsd_pkg::OP_TEXT, 1'b1, 64'd2, ENC_EXT16, 32'hFF00A55A, 2);

		set_limits(17'd65536, 17'd65536, 16'd65535);
		rand_phase(12);

		set_limits(17'($urandom_range(130, 65536)), 17'($urandom_range(0, 200)),
			16'($urandom_range(0, 200)));
		write_reg(REG_UNUSED, 17'($urandom));
		rand_phase(12);

		// all limits zero: only empty frames get through
		set_limits('0, '0, '0);
		rand_phase(6);

		tx_idle_phase = 1'b0;
		tx_idle       = 1'b0;
		rx_idle       = 1'b0;
		set_limits(17'($urandom_range(140, 300)), 17'($urandom_range(5, 20)),
			16'($urandom_range(5, 20)));
		rand_phase(12);
		error_frame();

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/wsd_queue.sv
rtl/websocket_frame_deframer_top.sv
test/testbench.sv
